// ===== src/xjr_pkg.sv =====
// Package for the xoroshiro128+ generator block: payload structs, op codes,
// generator constants, jump polynomials and the controller/datapath interface.
// No dependencies.
package xjr_pkg;

  // Op codes carried by an input transaction
  localparam logic [2:0] OP_SEED  = 3'd0;
  localparam logic [2:0] OP_DRAW  = 3'd1;
  localparam logic [2:0] OP_RANGE = 3'd2;
  localparam logic [2:0] OP_SJUMP = 3'd3;
  localparam logic [2:0] OP_LJUMP = 3'd4;

  // Generator reset state and mixing constants
  localparam logic [63:0] RESET_WORD_A = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] RESET_WORD_B = 64'hbf58476d1ce4e5b9;
  localparam int unsigned ROT_A   = 24;
  localparam int unsigned SHIFT_A = 16;
  localparam int unsigned ROT_B   = 37;

  // Jump polynomials, bit 0 of the low word first
  localparam logic [127:0] SHORT_POLY = {64'h170865df4b3201fc, 64'hdf900294d8f554a5};
  localparam logic [127:0] LONG_POLY  = {64'hdddf9b1090aa7ac1, 64'hd2a98b26625eee7b};
  localparam int unsigned JUMP_STEPS  = 128;
  localparam int unsigned JUMP_CNT_W  = $clog2(JUMP_STEPS) + 1;
  localparam int unsigned JUMP_IDX_W  = $clog2(JUMP_STEPS);

  // Serial divider: 33-bit dividend and divisor (bucket can reach 2^32)
  localparam int unsigned DIV_W     = 33;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] TWO_POW_32 = {1'b1, 32'd0};

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] seed_first;
    logic [63:0] seed_second;
    logic [31:0] range_limit;
  } xjr_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } xjr_out_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } gen_state_t;

  // Output register source select
  typedef enum logic [2:0] {
    SRC_SUM,
    SRC_QUO,
    SRC_ZERO,
    SRC_ACC_A,
    SRC_ACC_B
  } out_src_t;

  // Controller to datapath
  typedef struct packed {
    logic     take;
    logic     seed_load;
    logic     gen_step;
    logic     jump_clear;
    logic     jump_long;
    logic     jump_step;
    logic     div_start_bkt;
    logic     div_start_quo;
    logic     bucket_load;
    logic     out_load;
    out_src_t out_src;
    logic     out_last;
  } xjr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic limit_zero;
    logic q_fits;
    logic jump_last;
    logic div_done;
    logic div_busy;
  } xjr_stat_t;

  // One xoroshiro128+ state update
  function automatic gen_state_t gen_next(gen_state_t s);
    logic [63:0] x;
    gen_state_t  n;
    x   = s.b ^ s.a;
    n.a = ((s.a << ROT_A) | (s.a >> (64 - ROT_A))) ^ x ^ (x << SHIFT_A);
    n.b = (x << ROT_B) | (x >> (64 - ROT_B));
    return n;
  endfunction

endpackage

// ===== src/xjr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on xjr_pkg for widths.
module xjr_div import xjr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;
  logic                 ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem, quotient[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs};
    diff   = rem_sh - {1'b0, dvs};
  end

  // Iterate; quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/xjr_dp.sv =====
// Datapath: generator state, jump accumulators, ranged-draw divider and
// output register. Depends on xjr_pkg and xjr_div.
module xjr_dp import xjr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  xjr_in_t   in_data,
  input  xjr_cmd_t  cmd,
  output xjr_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output xjr_out_t  out_data
);

  gen_state_t            gen;
  gen_state_t            gen_nx;
  logic [63:0]           acc_a;
  logic [63:0]           acc_b;
  logic [JUMP_CNT_W-1:0] jump_count;
  logic                  jump_long;
  logic                  poly_bit;
  logic [31:0]           limit;
  logic [DIV_W-1:0]      bucket;
  logic [63:0]           sum;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic                  div_busy;
  logic                  div_done;
  logic [DIV_W-1:0]      div_q;
  logic [63:0]           out_value_next;

  assign sum    = gen.a + gen.b;
  assign gen_nx = gen_next(gen);

  // Pick the polynomial bit for this jump step
  assign poly_bit = jump_long ? LONG_POLY[jump_count[JUMP_IDX_W-1:0]]
                              : SHORT_POLY[jump_count[JUMP_IDX_W-1:0]];

  // Divider operands: bucket size first, then each draw over the bucket
  assign div_start    = cmd.div_start_bkt | cmd.div_start_quo;
  assign div_dividend = cmd.div_start_bkt ? TWO_POW_32 : {1'b0, sum[63:32]};
  assign div_divisor  = cmd.div_start_bkt ? {1'b0, limit} : bucket;

  xjr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Report status to the controller
  always_comb begin
    stat.out_free   = !out_valid || out_ready;
    stat.limit_zero = limit == 32'd0;
    stat.q_fits     = div_q < {1'b0, limit};
    stat.jump_last  = jump_count == JUMP_CNT_W'(JUMP_STEPS - 1);
    stat.div_done   = div_done;
    stat.div_busy   = div_busy;
  end

  // Load or advance the generator
  always_ff @(posedge clk) begin
    if (rst) begin
      gen.a <= RESET_WORD_A;
      gen.b <= RESET_WORD_B;
    end else if (cmd.seed_load) begin
      gen.a <= in_data.seed_first;
      gen.b <= in_data.seed_second;
    end else if (cmd.gen_step || cmd.jump_step) begin
      gen <= gen_nx;
    end
  end

  // Accumulate the jumped state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_a      <= '0;
      acc_b      <= '0;
      jump_count <= '0;
      jump_long  <= 1'b0;
    end else if (cmd.jump_clear) begin
      acc_a      <= '0;
      acc_b      <= '0;
      jump_count <= '0;
      jump_long  <= cmd.jump_long;
    end else if (cmd.jump_step) begin
      if (poly_bit) begin
        acc_a <= acc_a ^ gen.a;
        acc_b <= acc_b ^ gen.b;
      end
      jump_count <= jump_count + 1'b1;
    end
  end

  // Hold the limit and bucket of the ranged draw
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      limit <= in_data.range_limit;
    end
    if (cmd.bucket_load) begin
      bucket <= div_q;
    end
  end

  // Select the result word
  always_comb begin
    case (cmd.out_src)
      SRC_SUM:   out_value_next = sum;
      SRC_QUO:   out_value_next = {32'd0, div_q[31:0]};
      SRC_ACC_A: out_value_next = acc_a;
      SRC_ACC_B: out_value_next = acc_b;
      default:   out_value_next = 64'd0;
    endcase
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data.value <= out_value_next;
      out_data.last  <= cmd.out_last;
    end
  end

endmodule

// ===== src/xjr_ctrl.sv =====
// Controller state machine: decodes ops and sequences draws, ranged draws
// and jumps. Depends on xjr_pkg.
module xjr_ctrl import xjr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [2:0] in_op,
  input  xjr_stat_t stat,
  output xjr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_RNG_BKT,
    ST_RNG_ZERO,
    ST_RNG_BWAIT,
    ST_RNG_STEP,
    ST_RNG_QWAIT,
    ST_RNG_EMIT,
    ST_JMP,
    ST_JMP_A,
    ST_JMP_B
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == ST_IDLE;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_src = SRC_ZERO;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (in_op) inside
            OP_SEED:  cmd.seed_load = 1'b1;
            OP_DRAW:  state_next = ST_DRAW;
            OP_RANGE: state_next = ST_RNG_BKT;
            OP_SJUMP, OP_LJUMP: begin
              cmd.jump_clear = 1'b1;
              cmd.jump_long  = in_op == OP_LJUMP;
              state_next     = ST_JMP;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DRAW: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_SUM;
          cmd.out_last = 1'b1;
          cmd.gen_step = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_RNG_BKT: begin
        if (stat.limit_zero) begin
          state_next = ST_RNG_ZERO;
        end else begin
          cmd.div_start_bkt = 1'b1;
          state_next        = ST_RNG_BWAIT;
        end
      end
      ST_RNG_ZERO: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_ZERO;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_RNG_BWAIT: begin
        if (stat.div_done) begin
          cmd.bucket_load = 1'b1;
          state_next      = ST_RNG_STEP;
        end
      end
      ST_RNG_STEP: begin
        cmd.gen_step      = 1'b1;
        cmd.div_start_quo = 1'b1;
        state_next        = ST_RNG_QWAIT;
      end
      ST_RNG_QWAIT: begin
        if (stat.div_done) begin
          state_next = stat.q_fits ? ST_RNG_EMIT : ST_RNG_STEP;
        end
      end
      ST_RNG_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_QUO;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_JMP: begin
        cmd.jump_step = 1'b1;
        if (stat.jump_last) begin
          state_next = ST_JMP_A;
        end
      end
      ST_JMP_A: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_ACC_A;
          state_next   = ST_JMP_B;
        end
      end
      ST_JMP_B: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_ACC_B;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/xoroshiro_generator_jump_range_top.sv =====
// xoroshiro128+ random source with seed load, 64-bit draws, uniform draws
// below a limit and short/long jumps. Transactions are taken one at a time.
// A jump runs 128 steps of the generator, one per cycle, then sends out the
// two accumulated state words. A ranged draw first divides 2^32 by the limit
// on the serial divider to get the bucket size, then divides each draw by
// the bucket and rejects it until the quotient is below the limit, then
// emits that quotient; a zero limit emits zero. A finished result waits in
// the output register while the next transaction is taken. Depends on
// xjr_pkg, xjr_ctrl, xjr_dp and xjr_div.
module xoroshiro_generator_jump_range_top import xjr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  xjr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output xjr_out_t out_data
);

  xjr_cmd_t  cmd;
  xjr_stat_t stat;

  xjr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_data.op),
    .stat     (stat),
    .cmd      (cmd)
  );

  xjr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Never restart the divider mid-division
  assert property (@(posedge clk) disable iff (rst)
    (cmd.div_start_bkt || cmd.div_start_quo) |-> !stat.div_busy)
    else $error("divider started while busy");

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // No new transaction while a jump is stepping
  assert property (@(posedge clk) disable iff (rst)
    cmd.jump_step |-> !in_ready)
    else $error("input accepted during jump");

  // A jump's second word follows its first with the last flag set
  assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_src == SRC_ACC_B) |=> (out_valid && out_data.last))
    else $error("jump second word lost its last flag");

endmodule
